/* design/text_encoding_detector_macros.svh */
// Assertion macros shared by the checker of the text encoding detector.
`ifndef TEXT_ENCODING_DETECTOR_MACROS_SVH
`define TEXT_ENCODING_DETECTOR_MACROS_SVH

// Implication in the same cycle, silent while reset is held.
`define TEDET_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle, silent while reset is held.
`define TEDET_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Implication in the next cycle that also watches the reset itself.
`define TEDET_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

/* design/tedet_pkg.sv */
// Package of the text encoding detector: verdict codes, mark bytes and state type.
package tedet_pkg;

    // Verdict codes
    localparam logic [2:0] ENC_8BIT       = 3'd0;
    localparam logic [2:0] ENC_16BE       = 3'd1;
    localparam logic [2:0] ENC_16LE       = 3'd2;
    localparam logic [2:0] ENC_UTF8_BOM   = 3'd3;
    localparam logic [2:0] ENC_UTF8_NOBOM = 3'd4;

    // Byte-order mark bytes
    localparam logic [7:0] BYTE_FE = 8'hFE;
    localparam logic [7:0] BYTE_FF = 8'hFF;
    localparam logic [7:0] BYTE_EF = 8'hEF;
    localparam logic [7:0] BYTE_BB = 8'hBB;
    localparam logic [7:0] BYTE_BF = 8'hBF;

    // Bit positions in the mark flags
    localparam int FLAG_BE   = 0;
    localparam int FLAG_LE   = 1;
    localparam int FLAG_UTF8 = 2;

    // Detector state carried from one word to the next.
    typedef struct packed {
        logic [1:0] byte_position;
        logic [2:0] bom_match_flags;
        logic [1:0] pending_continuations;
        logic       pending_bad;
        logic       rejected;
        logic       ascii_only;
    } t_state;

    localparam t_state STATE_INIT = '{
        byte_position:         2'd0,
        bom_match_flags:       3'b111,
        pending_continuations: 2'd0,
        pending_bad:           1'b0,
        rejected:              1'b0,
        ascii_only:            1'b1
    };

endpackage

/* design/tedet_if.sv */
// Handshake interfaces of the text encoding detector: byte channel and verdict channel.
interface tedet_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface tedet_enc_if;
    logic       valid;
    logic       ready;
    logic [2:0] encoding;

    modport source (output valid, output encoding, input ready);
    modport sink   (input valid, input encoding, output ready);
endinterface

/* design/tedet_step.sv */
// Next-state and verdict logic of the detector for one byte.
module tedet_step (
    input  tedet_pkg::t_state i_state,
    input  logic [7:0]        i_byte,
    output tedet_pkg::t_state o_state,
    output logic [2:0]        o_encoding
);
    import tedet_pkg::*;

    logic [2:0] mark_mask;
    logic [2:0] flags;
    logic [1:0] pos_next;
    logic       cont_bad;
    logic [1:0] cont_left;
    t_state     nxt;

    // Mark matching: which marks the byte at this position still allows.
    always_comb begin
        case (i_state.byte_position)
            2'd0: begin
                mark_mask = {i_byte == BYTE_EF, i_byte == BYTE_FF, i_byte == BYTE_FE};
            end
            2'd1: begin
                mark_mask = {i_byte == BYTE_BB, i_byte == BYTE_FE, i_byte == BYTE_FF};
            end
            2'd2: begin
                mark_mask = {i_byte == BYTE_BF, 2'b11};
            end
            default: begin
                mark_mask = 3'b111;
            end
        endcase
    end

    assign flags     = i_state.bom_match_flags & mark_mask;
    assign pos_next  = (i_state.byte_position == 2'd3) ? 2'd3 : i_state.byte_position + 2'd1;
    assign cont_bad  = i_state.pending_bad | (i_byte[7:6] != 2'b10);
    assign cont_left = i_state.pending_continuations - 2'd1;

    // UTF-8 validation of one byte.
    always_comb begin
        nxt                 = i_state;
        nxt.byte_position   = pos_next;
        nxt.bom_match_flags = flags;
        if (i_state.rejected) begin
            nxt.rejected = 1'b1;
        end else if (i_state.pending_continuations != 2'd0) begin
            // A byte owed to an open sequence is never read as a lead.
            nxt.pending_continuations = cont_left;
            if (cont_left == 2'd0) begin
                nxt.rejected    = cont_bad;
                nxt.pending_bad = 1'b0;
            end else begin
                nxt.pending_bad = cont_bad;
            end
        end else begin
            case (i_byte) inside
                8'h00: begin
                    nxt.ascii_only = 1'b0;
                    nxt.rejected   = 1'b1;
                end
                [8'h01:8'h7F]: begin
                end
                [8'hC0:8'hDF]: begin
                    nxt.ascii_only            = 1'b0;
                    nxt.pending_continuations = 2'd1;
                    nxt.pending_bad           = (i_byte[4:0] == 5'd0);
                end
                [8'hE0:8'hEF]: begin
                    nxt.ascii_only            = 1'b0;
                    nxt.pending_continuations = 2'd2;
                    nxt.pending_bad           = (i_byte[3:0] == 4'd0);
                end
                default: begin
                    // Stray continuation or a lead of F0 and above.
                    nxt.ascii_only = 1'b0;
                    nxt.rejected   = 1'b1;
                end
            endcase
        end
    end

    // Verdict as it would stand if this byte ended the stream.
    always_comb begin
        if (pos_next >= 2'd2 && flags[FLAG_BE]) begin
            o_encoding = ENC_16BE;
        end else if (pos_next >= 2'd2 && flags[FLAG_LE]) begin
            o_encoding = ENC_16LE;
        end else if (pos_next == 2'd3 && flags[FLAG_UTF8]) begin
            o_encoding = ENC_UTF8_BOM;
        end else if (!nxt.ascii_only && !nxt.rejected) begin
            o_encoding = ENC_UTF8_NOBOM;
        end else begin
            o_encoding = ENC_8BIT;
        end
    end

    assign o_state = nxt;

endmodule

/* design/text_encoding_detector.sv */
// Top level of the text encoding detector: input register, step logic, verdict register.
//
//  channel | direction | word                     | accepted when
//  i_in    | in        | byte_value, last_byte    | valid && ready at rising i_clk
//  o_out   | out       | encoding                 | valid && ready at rising i_clk
//
// One byte a cycle is taken while no last byte waits on a stalled verdict; each byte
// is held in the input register and the step logic updates the stream state as it
// leaves it. A verdict is written to the output register as the last byte leaves the
// input register.
// Synchronous active-low reset clears both valid flags and returns the stream state.
// A stalled verdict holds the output register; ordinary bytes still flow past it and
// only a further last byte waits until the verdict is taken.
module text_encoding_detector (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tedet_byte_if.sink  i_in,
    tedet_enc_if.source o_out
);
    import tedet_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    logic [2:0] r_out_enc;
    logic [2:0] n_out_enc;
    logic       out_free;
    logic       stage_move;

    // Flow control between the two registers.
    assign out_free   = !r_out_valid || o_out.ready;
    assign stage_move = r_in_valid && (!r_in_last || out_free);
    assign i_in.ready = !r_in_valid || stage_move;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.byte_value;
            r_in_last <= i_in.last_byte;
        end
    end

    tedet_step u_step (
        .i_state    (r_state),
        .i_byte     (r_in_byte),
        .o_state    (n_state),
        .o_encoding (n_out_enc)
    );

    // Stream state; a last byte returns it to its initial value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_INIT;
        end else if (stage_move) begin
            r_state <= r_in_last ? STATE_INIT : n_state;
        end
    end

    // Verdict register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= stage_move && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_move && r_in_last) begin
            r_out_enc <= n_out_enc;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.encoding = r_out_enc;

endmodule

/* design/tedet_checker.sv */
// Port checker of the text encoding detector and its bind to the top level.
`include "text_encoding_detector_macros.svh"

module tedet_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_last,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_out_encoding
);
    import tedet_pkg::*;

    logic [1:0] r_open;
    logic       last_acc;
    logic       out_acc;

    assign last_acc = i_in_valid && i_in_ready && i_in_last;
    assign out_acc  = i_out_valid && i_out_ready;

    // Streams ended whose verdict is not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 2'd0;
        end else if (last_acc && !out_acc) begin
            r_open <= r_open + 2'd1;
        end else if (out_acc && !last_acc) begin
            r_open <= r_open - 2'd1;
        end
    end

    `TEDET_ASSERT_NOW(a_no_invented, out_acc, r_open != 2'd0, "verdict without an ended stream")
    `TEDET_ASSERT_NOW(a_bounded, 1'b1, r_open != 2'd3, "more than two verdicts owed")
    `TEDET_ASSERT_NOW(a_ready_free, !i_out_valid, i_in_ready, "input stalled with no verdict held")
    `TEDET_ASSERT_NEXT(a_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_encoding), "stalled verdict changed")
    `TEDET_ASSERT_RST(a_reset, !i_rst_n, !i_out_valid, "verdict valid after reset")

endmodule

bind text_encoding_detector tedet_checker u_tedet_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_last      (i_in.last_byte),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_encoding (o_out.encoding)
);
